@@ rtl/core/lmf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmf_pkg - shared types and constants of the Laplacian mirror filter
// Item descriptor passed from front to back, line-buffer entry layout,
// result layout, register indexes and fixed sizes.
// ----------------------------------------------------------------------------
package lmf_pkg;

  localparam int CFG_W       = 12;  // width of the size registers
  localparam int PIX_W       = 8;
  localparam int QUEUE_DEPTH = 4;   // power of two

  localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 12'd512;
  localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 12'd512;
  localparam logic [CFG_W-1:0] MIN_FRAME_SIZE     = 12'd2;

  localparam logic [PIX_W-1:0] CLAMP_MAX = 8'd255;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } lmf_reg_t;

  // One classified item, front to back
  typedef struct packed {
    logic             drain;      // flush step of the last row
    logic             emit;       // produces a result
    logic             last_col;   // last column of the row
    logic             first_col;  // column zero
    logic             first_row;  // output row zero: row above mirrors to row one
    logic [PIX_W-1:0] pixel;
  } lmf_item_t;

  // Line-buffer entry: row above and output row at one column
  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] centre;
  } lmf_entry_t;

  typedef struct packed {
    logic             end_of_frame;
    logic             end_of_row;
    logic [PIX_W-1:0] filtered_value;
  } lmf_result_t;

endpackage

@@ rtl/core/lmf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmf_queue - small register FIFO
// Holds up to QUEUE_DEPTH beats; reports full, empty and fill level.
// ----------------------------------------------------------------------------
module lmf_queue
  import lmf_pkg::*;
#(
  parameter int DW = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  input  logic [DW-1:0]                      push_data,
  input  logic                               pop,
  output logic [DW-1:0]                      pop_data,
  output logic                               empty,
  output logic                               full,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   level
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int LW = $clog2(QUEUE_DEPTH+1);

  logic [DW-1:0] slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + LW'(push) - LW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = slot_r[rd_ptr_r];
  assign empty    = (count_r == '0);
  assign full     = (count_r == LW'(QUEUE_DEPTH));
  assign level    = count_r;

endmodule

@@ rtl/core/lmf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmf_front - input acceptance and item classification
// Tracks column and row, clamps the frame size, drops drain beats that
// arrive during the pixel phase and pushes one descriptor per kept beat.
// ----------------------------------------------------------------------------
module lmf_front
  import lmf_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [CFG_W-1:0]              frame_width,
  input  logic [CFG_W-1:0]              frame_height,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [PIX_W-1:0]              pixel_value,
  input  logic                          drain,
  input  logic                          queue_full,
  output logic                          push,
  output lmf_item_t                     push_item,
  output logic [$clog2(MAX_WIDTH)-1:0]  push_col
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int MW = $clog2(MAX_WIDTH+1);
  localparam int WW = (MW > CFG_W) ? MW : CFG_W;

  logic [CW-1:0]    col_r, col_nxt;
  logic [CFG_W-1:0] row_r, row_nxt;

  logic [WW-1:0]    width_ext, width_eff, width_m1;
  logic [CFG_W-1:0] height_eff;
  logic             accept, drain_phase, last_col, dropped;

  always_comb begin
    width_ext = WW'(frame_width);
    priority if (width_ext > WW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else if (width_ext < WW'(MIN_FRAME_SIZE)) begin
      width_eff = WW'(MIN_FRAME_SIZE);
    end else begin
      width_eff = width_ext;
    end
    width_m1   = width_eff - WW'(1);
    height_eff = (frame_height < MIN_FRAME_SIZE) ? MIN_FRAME_SIZE : frame_height;

    last_col    = (WW'(col_r) >= width_m1);
    drain_phase = (row_r >= height_eff);
    dropped     = drain && !drain_phase;

    in_tready = !queue_full;
    accept    = in_tvalid && in_tready;
    push      = accept && !dropped;

    push_item.drain     = drain_phase;
    push_item.emit      = drain_phase || (row_r != '0);
    push_item.last_col  = last_col;
    push_item.first_col = (col_r == '0);
    push_item.first_row = (row_r == CFG_W'(1));
    push_item.pixel     = pixel_value;
    push_col            = col_r;

    col_nxt = col_r;
    row_nxt = row_r;
    if (push) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = drain_phase ? '0 : row_r + CFG_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

@@ rtl/core/lmf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmf_back - line buffer, kernel evaluation and result buffer
// Pops a descriptor, reads the line buffer at the column and the one to its
// right, forwards the previous write, updates the line buffer and pushes
// the clamped response into the result FIFO.
// ----------------------------------------------------------------------------
module lmf_back
  import lmf_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          queue_empty,
  input  lmf_item_t                     queue_item,
  input  logic [$clog2(MAX_WIDTH)-1:0]  queue_col,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output lmf_result_t                   out_result
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = $clog2(QUEUE_DEPTH+1);
  localparam int RW = $bits(lmf_result_t);

  lmf_entry_t mem [MAX_WIDTH];

  // evaluation stage
  logic             eval_valid_r;
  lmf_item_t        eval_item_r;
  logic [CW-1:0]    eval_col_r, eval_colb_r;
  lmf_entry_t       rd_a_r, rd_b_r;

  // write forwarding for the write that coincided with the read
  logic             fwd_valid_r;
  logic [CW-1:0]    fwd_col_r;
  lmf_entry_t       fwd_entry_r;

  logic [PIX_W-1:0] left_nb_r, left_nb_nxt;  // old output-row pixel left of column
  logic [PIX_W-1:0] prev_r, prev_nxt;        // current output-row pixel left of column

  logic [CW-1:0]    rd_colb;
  logic [LW-1:0]    out_level;
  logic             out_empty, out_full, out_push;
  lmf_result_t      res;
  logic [RW-1:0]    out_data;

  logic [PIX_W-1:0] mid, up_mem, right_mem, up, down, left, right;
  logic [9:0]       pos_sum, neg_sum, mag;
  logic [12:0]      scaled;
  logic             wr_en;
  lmf_entry_t       wr_entry;

  // Pop only when the result FIFO can take every beat in flight
  assign pop     = !queue_empty && ((LW+1)'(out_level) + (LW+1)'(eval_valid_r)
                                    < (LW+1)'(QUEUE_DEPTH));
  assign rd_colb = queue_item.last_col ? queue_col : queue_col + CW'(1);

  always_comb begin
    mid       = rd_a_r.centre;
    up_mem    = rd_a_r.upper;
    right_mem = rd_b_r.centre;
    if (fwd_valid_r && (fwd_col_r == eval_col_r)) begin
      mid    = fwd_entry_r.centre;
      up_mem = fwd_entry_r.upper;
    end
    if (fwd_valid_r && (fwd_col_r == eval_colb_r)) begin
      right_mem = fwd_entry_r.centre;
    end

    if (eval_item_r.drain) begin
      up    = up_mem;
      down  = up_mem;
      left  = eval_item_r.first_col ? right_mem : prev_r;
      right = eval_item_r.last_col  ? prev_r    : right_mem;
    end else begin
      up    = eval_item_r.first_row ? eval_item_r.pixel : up_mem;
      down  = eval_item_r.pixel;
      left  = eval_item_r.first_col ? right_mem : left_nb_r;
      right = eval_item_r.last_col  ? left_nb_r : right_mem;
    end

    pos_sum = 10'(up) + 10'(down) + 10'(left) + 10'(right);
    neg_sum = {mid, 2'b00};
    mag     = (pos_sum >= neg_sum) ? pos_sum - neg_sum : neg_sum - pos_sum;
    scaled  = {1'b0, mag, 2'b00} + 13'(mag);  // times five

    res.filtered_value = (scaled > 13'(CLAMP_MAX)) ? CLAMP_MAX : scaled[PIX_W-1:0];
    res.end_of_row     = eval_item_r.last_col;
    res.end_of_frame   = eval_item_r.drain && eval_item_r.last_col;

    wr_en           = eval_valid_r && !eval_item_r.drain;
    wr_entry.upper  = mid;
    wr_entry.centre = eval_item_r.pixel;
    out_push        = eval_valid_r && eval_item_r.emit;

    left_nb_nxt = left_nb_r;
    prev_nxt    = prev_r;
    if (eval_valid_r) begin
      if (eval_item_r.drain) begin
        prev_nxt = mid;
      end else begin
        left_nb_nxt = mid;
        prev_nxt    = eval_item_r.pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[eval_col_r] <= wr_entry;
    end
    if (pop) begin
      rd_a_r <= mem[queue_col];
      rd_b_r <= mem[rd_colb];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_valid_r <= 1'b0;
      fwd_valid_r  <= 1'b0;
      left_nb_r    <= '0;
      prev_r       <= '0;
    end else begin
      eval_valid_r <= pop;
      fwd_valid_r  <= wr_en;
      left_nb_r    <= left_nb_nxt;
      prev_r       <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      eval_item_r <= queue_item;
      eval_col_r  <= queue_col;
      eval_colb_r <= rd_colb;
    end
    fwd_col_r   <= eval_col_r;
    fwd_entry_r <= wr_entry;
  end

  lmf_queue #(
    .DW (RW)
  ) u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (out_push),
    .push_data (res),
    .pop       (out_tvalid && out_tready),
    .pop_data  (out_data),
    .empty     (out_empty),
    .full      (out_full),
    .level     (out_level)
  );

  assign out_tvalid = !out_empty && !(out_full && 1'b0);
  assign out_result = out_data;

endmodule

@@ rtl/core/laplacian_3x3_mirror_filter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplacian_3x3_mirror_filter_unit - 4-neighbour Laplacian on a pixel stream
// Mirrored edges, response |sum| times five clamped at 255.
// ----------------------------------------------------------------------------
// Usage:
//   Feed 8-bit pixels in raster order on the in_ channel (in_tuser low), one
//   beat per cycle. The result for pixel (r,c) leaves when pixel (r+1,c) is
//   taken; after the last pixel send frame_width beats with in_tuser high to
//   flush the last row. A flush beat during the pixel phase is dropped.
//   out_tlast marks the last pixel of each row, out_tuser the last pixel of
//   the frame.
//   Throughput: one beat per cycle on both sides while neither side stalls.
//   A taken beat passes the input queue, the line-buffer read and the
//   kernel evaluation into the result FIFO before out_tvalid rises.
//   The line buffer has one write and two read ports; the beat at a column
//   reads that column and the next, and a one-entry forward covers the write
//   issued in the same cycle.
//   Reset clears counters and queues, and sets both size registers to 512;
//   the line buffer is not cleared, the first frame row fills it.
//   When out_tready is low, results collect in a four-beat FIFO, then the
//   four-beat input queue fills and in_tready drops; no beat is lost.
//   Write frame_width / frame_height through cfg_ only while idle.
// ----------------------------------------------------------------------------
module laplacian_3x3_mirror_filter_unit
  import lmf_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  // input pixels
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel_value
  input  logic        in_tuser,   // [0] drain
  // filtered pixels
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] filtered_value
  output logic        out_tlast,  // end_of_row
  output logic        out_tuser,  // [0] end_of_frame
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int QW = $bits(lmf_item_t) + CW;

  logic [CFG_W-1:0] frame_width_r, frame_width_nxt;
  logic [CFG_W-1:0] frame_height_r, frame_height_nxt;

  logic          q_push, q_pop, q_empty, q_full;
  lmf_item_t     front_item, back_item;
  logic [CW-1:0] front_col, back_col;
  logic [QW-1:0] q_out;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_level;
  lmf_result_t   result;

  // Size registers: always ready, writes land at the handshake edge
  assign cfg_ready = 1'b1;

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_valid && cfg_ready) begin
      unique case (lmf_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width_nxt  = cfg_data;
        REG_FRAME_HEIGHT: frame_height_nxt = cfg_data;
        default:          frame_width_nxt  = frame_width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RESET_FRAME_WIDTH;
      frame_height_r <= RESET_FRAME_HEIGHT;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
    end
  end

  // Front: count position, classify, drop stray flush beats
  lmf_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .pixel_value  (in_tdata),
    .drain        (in_tuser),
    .queue_full   (q_full),
    .push         (q_push),
    .push_item    (front_item),
    .push_col     (front_col)
  );

  // Descriptor queue between the two halves
  lmf_queue #(
    .DW (QW)
  ) u_item_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({front_col, front_item}),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty),
    .full      (q_full),
    .level     (q_level)
  );

  assign back_item = q_out[$bits(lmf_item_t)-1:0];
  assign back_col  = q_out[QW-1:$bits(lmf_item_t)];

  // Back: line buffer, kernel, result FIFO
  lmf_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .queue_empty (q_empty),
    .queue_item  (back_item),
    .queue_col   (back_col),
    .pop         (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_result  (result)
  );

  assign out_tdata = result.filtered_value;
  assign out_tlast = result.end_of_row;
  assign out_tuser = result.end_of_frame;

endmodule
